/* hdl/http_request_line_parser_core_defines.svh */
// assertion macros for the request line parser
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, cleared during reset
`define HRLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, cleared during reset
`define HRLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hrlp_pkg.sv */
// types, codes and constants shared by the request line parser
`default_nettype none

package hrlp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_METHOD = 4'b0010,
    PH_PATH   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic       is_status;
    logic [7:0] path_char;
    logic [7:0] path_position;
    status_t    status;
    logic       method_is_get;
  } result_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_NL) || (b == CH_NUL);
  endfunction

  // letters of the only supported method
  function automatic logic [7:0] get_letter(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/http_request_line_parser_core.sv */
// request line parser top level with output register
`default_nettype none

// channel  | handshake           | word
// in_      | in_valid/in_ready   | data_byte, request_start
// out_     | out_valid/out_ready | is_status, path_char, path_position, status, method_is_get
//
// one byte per cycle while in_ready is high; a result appears in the cycle after its byte is taken
// the state update and result selection sit between the input port and the output register
// in_ready stays high while the output register is empty or being drained
// synchronous active-low reset returns the parser to idle and empties the output register

module http_request_line_parser_core #(
  parameter int METHOD_MAX  = 10,
  parameter int PATH_BUFFER = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_request_start,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_status,
  output logic [7:0]      out_path_char,
  output logic [7:0]      out_path_position,
  output logic [1:0]      out_status,
  output logic            out_method_is_get
);

  logic              in_accept;
  logic              res_valid;
  hrlp_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  hrlp_pkg::result_t out_res_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  hrlp_ctrl #(
    .METHOD_MAX  (METHOD_MAX),
    .PATH_BUFFER (PATH_BUFFER)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .data_byte     (in_data_byte),
    .request_start (in_request_start),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_status     = out_res_r.is_status;
  assign out_path_char     = out_res_r.path_char;
  assign out_path_position = out_res_r.path_position;
  assign out_status        = out_res_r.status;
  assign out_method_is_get = out_res_r.method_is_get;

endmodule

`default_nettype wire

/* hdl/hrlp_ctrl.sv */
// parser state and per-word result logic
`default_nettype none

module hrlp_ctrl #(
  parameter int METHOD_MAX  = 10,
  parameter int PATH_BUFFER = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              request_start,
  output logic                   res_valid,
  output hrlp_pkg::result_t      res
);

  localparam int MCW = $clog2(METHOD_MAX + 1);
  localparam int PCW = $clog2(PATH_BUFFER);
  localparam logic [MCW-1:0] MC_MAX   = MCW'(METHOD_MAX);
  localparam logic [MCW-1:0] MC_GET   = MCW'(3);
  localparam logic [PCW-1:0] PC_LIMIT = PCW'(PATH_BUFFER - 2);

  hrlp_pkg::phase_t phase_r, phase_nxt;
  logic [MCW-1:0]   mc_r, mc_nxt;
  logic             gm_r, gm_nxt;
  logic [PCW-1:0]   pc_r, pc_nxt;

  hrlp_pkg::phase_t ph;
  logic [MCW-1:0]   mc;
  logic             gm;
  logic [PCW-1:0]   pc;
  logic [MCW-1:0]   mc_inc;
  logic [PCW+7:0]   pc_ext;
  logic             delim;

  always_comb begin
    ph     = request_start ? hrlp_pkg::PH_METHOD : phase_r;
    mc     = request_start ? '0 : mc_r;
    gm     = request_start ? 1'b1 : gm_r;
    pc     = request_start ? '0 : pc_r;
    mc_inc = mc + MCW'(1);
    pc_ext = {8'd0, pc};
    delim  = hrlp_pkg::is_delim(data_byte);

    phase_nxt = ph;
    mc_nxt    = mc;
    gm_nxt    = gm;
    pc_nxt    = pc;
    res_valid = 1'b0;
    res       = '0;

    case (ph)
      hrlp_pkg::PH_METHOD: begin
        if (!delim) begin
          if (mc < MC_GET) begin
            if (data_byte != hrlp_pkg::get_letter(mc[1:0])) gm_nxt = 1'b0;
          end else begin
            gm_nxt = 1'b0;
          end
          mc_nxt = mc_inc;
          if (mc_inc >= MC_MAX) begin
            phase_nxt  = hrlp_pkg::PH_DONE;
            res_valid  = 1'b1;
            res.is_status = 1'b1;
            res.status = hrlp_pkg::ST_INVALID;
          end
        end else if (mc == MC_GET && gm) begin
          if (data_byte == hrlp_pkg::CH_SPACE) begin
            phase_nxt = hrlp_pkg::PH_PATH;
            pc_nxt    = '0;
          end else begin
            phase_nxt         = hrlp_pkg::PH_DONE;
            res_valid         = 1'b1;
            res.is_status     = 1'b1;
            res.status        = hrlp_pkg::ST_INVALID;
            res.method_is_get = 1'b1;
          end
        end else begin
          phase_nxt     = hrlp_pkg::PH_DONE;
          res_valid     = 1'b1;
          res.is_status = 1'b1;
          res.status    = (mc == '0) ? hrlp_pkg::ST_INVALID : hrlp_pkg::ST_UNSUPPORTED;
        end
      end
      hrlp_pkg::PH_PATH: begin
        res_valid         = 1'b1;
        res.method_is_get = 1'b1;
        res.path_position = pc_ext[7:0];
        if (delim) begin
          phase_nxt     = hrlp_pkg::PH_DONE;
          res.is_status = 1'b1;
          res.status    = hrlp_pkg::ST_OK;
        end else if (pc >= PC_LIMIT) begin
          phase_nxt     = hrlp_pkg::PH_DONE;
          res.is_status = 1'b1;
          res.status    = hrlp_pkg::ST_TOO_LONG;
        end else begin
          pc_nxt        = pc + PCW'(1);
          res.path_char = data_byte;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrlp_pkg::PH_IDLE;
      mc_r    <= '0;
      gm_r    <= 1'b1;
      pc_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mc_r    <= mc_nxt;
      gm_r    <= gm_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/hrlp_checker.sv */
// port-level checks for the request line parser and their binding
`default_nettype none
`include "http_request_line_parser_core_defines.svh"

module hrlp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_is_status,
  input wire logic [7:0] out_path_char,
  input wire logic [7:0] out_path_position,
  input wire logic [1:0] out_status,
  input wire logic       out_method_is_get
);

  logic        stalled;
  logic        path_word;
  logic        early_status;
  logic [19:0] out_word;
  logic        path_ok;
  logic        method_err_ok;

  assign stalled      = out_valid && !out_ready;
  assign path_word    = out_valid && !out_is_status;
  assign early_status = out_valid && out_is_status && !out_method_is_get;
  assign out_word     = {out_is_status, out_path_char, out_path_position, out_status,
                         out_method_is_get};
  assign path_ok       = out_method_is_get && out_status == hrlp_pkg::ST_OK;
  assign method_err_ok = out_path_position == 8'd0 &&
                         (out_status == hrlp_pkg::ST_INVALID ||
                          out_status == hrlp_pkg::ST_UNSUPPORTED);

  `HRLP_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "result word changed while stalled")
  `HRLP_ASSERT_NOW(a_no_take_when_full, stalled, !in_ready, "input taken while output register full")
  `HRLP_ASSERT_NOW(a_path_word, path_word, path_ok, "path word without get or with status")
  `HRLP_ASSERT_NOW(a_status_char, out_valid && out_is_status, out_path_char == 8'd0, "status word carries a path byte")
  `HRLP_ASSERT_NOW(a_method_err, early_status, method_err_ok, "method-phase status malformed")

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (.*);

`default_nettype wire

/* dv/http_request_line_parser_core_tb.sv */
// self-checking testbench for the http request line parser core
`timescale 1ns / 1ps

module http_request_line_parser_core_tb;

  localparam int METHOD_MAX = 10;
  localparam int PATH_BUFFER = 256;
  localparam int ITEM_TARGET = 1450;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] GET_TEXT [3] = '{8'h47, 8'h45, 8'h54};

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic in_request_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_status;
  logic [7:0] out_path_char;
  logic [7:0] out_path_position;
  logic [1:0] out_status;
  logic out_method_is_get;

  byte_word_t pending_bytes[$];
  hrlp_pkg::result_t expected_words[$];

  // parser state as predicted
  hrlp_pkg::phase_t parse_phase = hrlp_pkg::PH_IDLE;
  int method_len = 0;
  bit get_so_far = 1'b1;
  int path_len = 0;

  int planned_items = 0;
  int total_bytes = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  http_request_line_parser_core #(
    .METHOD_MAX(METHOD_MAX),
    .PATH_BUFFER(PATH_BUFFER)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_request_start(in_request_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_is_status(out_is_status),
    .out_path_char(out_path_char),
    .out_path_position(out_path_position),
    .out_status(out_status),
    .out_method_is_get(out_method_is_get)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_separator(input logic [7:0] b);
    return (b == hrlp_pkg::CH_SPACE) || (b == hrlp_pkg::CH_NL) || (b == hrlp_pkg::CH_NUL);
  endfunction

  // advances the parser state by one byte; returns 1 when a word comes out
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output hrlp_pkg::result_t res);
    res = '0;
    if (start) begin
      parse_phase = hrlp_pkg::PH_METHOD;
      method_len = 0;
      get_so_far = 1'b1;
      path_len = 0;
    end
    if (parse_phase == hrlp_pkg::PH_METHOD) begin
      if (!is_separator(b)) begin
        if (method_len >= 3) begin
          get_so_far = 1'b0;
        end else if (b != GET_TEXT[method_len]) begin
          get_so_far = 1'b0;
        end
        method_len++;
        if (method_len >= METHOD_MAX) begin
          parse_phase = hrlp_pkg::PH_DONE;
          res.is_status = 1'b1;
          res.status = hrlp_pkg::ST_INVALID;
          return 1'b1;
        end
        return 1'b0;
      end
      if (method_len == 3 && get_so_far) begin
        if (b == hrlp_pkg::CH_SPACE) begin
          parse_phase = hrlp_pkg::PH_PATH;
          path_len = 0;
          return 1'b0;
        end
        parse_phase = hrlp_pkg::PH_DONE;
        res.is_status = 1'b1;
        res.status = hrlp_pkg::ST_INVALID;
        res.method_is_get = 1'b1;
        return 1'b1;
      end
      parse_phase = hrlp_pkg::PH_DONE;
      res.is_status = 1'b1;
      if (method_len == 0) begin
        res.status = hrlp_pkg::ST_INVALID;
      end else begin
        res.status = hrlp_pkg::ST_UNSUPPORTED;
      end
      return 1'b1;
    end
    if (parse_phase == hrlp_pkg::PH_PATH) begin
      res.method_is_get = 1'b1;
      res.path_position = path_len[7:0];
      if (is_separator(b)) begin
        parse_phase = hrlp_pkg::PH_DONE;
        res.is_status = 1'b1;
        res.status = hrlp_pkg::ST_OK;
        return 1'b1;
      end
      if (path_len + 1 >= PATH_BUFFER - 1) begin
        parse_phase = hrlp_pkg::PH_DONE;
        res.is_status = 1'b1;
        res.status = hrlp_pkg::ST_TOO_LONG;
        return 1'b1;
      end
      res.path_char = b;
      res.status = hrlp_pkg::ST_OK;
      path_len++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_separator(b));
    return b;
  endfunction

  function automatic logic [7:0] separator_byte();
    case ($urandom_range(0, 2))
      0: return hrlp_pkg::CH_SPACE;
      1: return hrlp_pkg::CH_NL;
      default: return hrlp_pkg::CH_NUL;
    endcase
  endfunction

  task automatic add_word(input logic [7:0] b, input logic start, input bit counted);
    byte_word_t w;
    w.data = b;
    w.start = start;
    pending_bytes.push_back(w);
    if (counted) planned_items++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_word(s[i], i == 0, 1'b1);
  endtask

  task automatic build_stimulus();
    int pick;
    int n;
    bit long_path_sent;
    long_path_sent = 1'b0;
    // bytes before any request start
    add_word(8'hA5, 1'b0, 1'b0);
    add_word(8'h5A, 1'b0, 1'b0);
    add_text("GET /");
    add_word(8'hFF, 1'b0, 1'b1);
    add_word(8'h80, 1'b0, 1'b1);
    add_word(8'h01, 1'b0, 1'b1);
    add_word(hrlp_pkg::CH_NL, 1'b0, 1'b1);
    add_text("GET ");
    add_word(hrlp_pkg::CH_NUL, 1'b0, 1'b1);
    add_text("GET\n");
    add_text("GET");
    add_word(hrlp_pkg::CH_NUL, 1'b0, 1'b1);
    add_word(hrlp_pkg::CH_SPACE, 1'b1, 1'b1);
    add_word(hrlp_pkg::CH_NUL, 1'b1, 1'b1);
    add_text("ABCDEFGHIJ");
    add_text("POST ");
    add_text("GETX ");
    // restart in the path and in the method
    add_text("GET /ab");
    add_text("GE");
    add_text("GET x ");

    while (planned_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_text("GET ");
        if ((!long_path_sent || $urandom_range(0, 49) == 0) &&
            planned_items + PATH_BUFFER + 8 < ITEM_TARGET) begin
          n = $urandom_range(PATH_BUFFER - 6, PATH_BUFFER + 2);
          long_path_sent = 1'b1;
        end else begin
          n = $urandom_range(0, 16);
        end
        repeat (n) add_word(text_byte(), 1'b0, 1'b1);
        // occasionally left open so that the next request restarts it
        if ($urandom_range(0, 9) != 0) add_word(separator_byte(), 1'b0, 1'b1);
      end else if (pick < 80) begin
        n = $urandom_range(0, METHOD_MAX + 2);
        if (n == 0) begin
          add_word(separator_byte(), 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            if (i < 3 && $urandom_range(0, 3) != 0) begin
              add_word(GET_TEXT[i], i == 0, 1'b1);
            end else begin
              add_word(text_byte(), i == 0, 1'b1);
            end
          end
          add_word(separator_byte(), 1'b0, 1'b1);
        end
      end else if (pick < 90) begin
        add_text("GET");
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
        end
      end
      // trailing bytes that the parser ignores unless the request is still open
      repeat ($urandom_range(0, 2)) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    total_bytes = pending_bytes.size();
  endtask

  // driver
  always @(posedge clk) begin
    hrlp_pkg::result_t exp_word;
    byte_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_data_byte, in_request_start, exp_word)) begin
          expected_words.push_back(exp_word);
        end
        bytes_taken++;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          w = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= w.data;
          in_request_start <= w.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hrlp_pkg::result_t exp_word;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: is_status %0d path_char %0d path_position %0d status %0d",
                 out_is_status, out_path_char, out_path_position, out_status);
          errors++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_is_status !== exp_word.is_status) begin
            $error("is_status: expected %0d, got %0d", exp_word.is_status, out_is_status);
            errors++;
          end
          if (out_path_char !== exp_word.path_char) begin
            $error("path_char: expected %0d, got %0d", exp_word.path_char, out_path_char);
            errors++;
          end
          if (out_path_position !== exp_word.path_position) begin
            $error("path_position: expected %0d, got %0d", exp_word.path_position,
                   out_path_position);
            errors++;
          end
          if (out_status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, out_status);
            errors++;
          end
          if (out_method_is_get !== exp_word.method_is_get) begin
            $error("method_is_get: expected %0d, got %0d", exp_word.method_is_get,
                   out_method_is_get);
            errors++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 4);
        // long back-pressure so the input side fills up and stalls
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (bytes_taken < total_bytes || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d words still expected at the end", expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* http_request_line_parser_core.f */
+incdir+hdl
hdl/hrlp_pkg.sv
hdl/hrlp_ctrl.sv
hdl/http_request_line_parser_core.sv
hdl/hrlp_checker.sv
dv/http_request_line_parser_core_tb.sv
